[hdl/sdca_dual_coordinate_step_assert.svh]
// Assertion macros shared by the dual coordinate step RTL
`ifndef SDCA_DUAL_COORDINATE_STEP_ASSERT_SVH
`define SDCA_DUAL_COORDINATE_STEP_ASSERT_SVH

// Same-cycle implication under reset
`define SDCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdca assertion failed");

// Next-cycle implication under reset
`define SDCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdca assertion failed");

`endif

[hdl/sdca_pkg.sv]
// Package: types and constants of the dual coordinate step block
`timescale 1ns / 1ps
package sdca_pkg;

    localparam int MAX_FEATURES_DEF = 256;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CNT_W_MAX        = 17;
    localparam int JQ_DEPTH         = 4;
    localparam int JQ_CNT_W         = $clog2(JQ_DEPTH + 1);

    localparam logic [30:0] L2_RESET   = 31'd65536;
    localparam logic [30:0] CEIL_RESET = 31'h7FFF_FFFF;

    // register select (paddr bit 2)
    localparam logic REG_L2   = 1'b0;
    localparam logic REG_CEIL = 1'b1;

    typedef struct packed {
        logic signed [31:0] feature_value;
        logic signed [31:0] primal_value;
        logic [30:0]        dual_value;
        logic               row_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] delta_dual;
        logic               zero_norm;
    } out_item_t;

    // one closed row handed from the front to the solver
    typedef struct packed {
        logic [63:0]          norm;
        logic signed [63:0]   dot;
        logic [CNT_W_MAX-1:0] cnt;
        logic [30:0]          dual;
    } job_t;

endpackage

[hdl/sdca_front.sv]
// Front end: multiply, accumulate with saturation and close rows into jobs
`timescale 1ns / 1ps
module sdca_front
    import sdca_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  in_item_t            in_data,
    output logic                full,
    input  logic [JQ_CNT_W-1:0] q_count,
    output logic                job_push,
    output job_t                job
);

    localparam int CW = $clog2(MAX_FEATURES + 1);

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               s1_valid_reg, s1_last_reg, s1_use_reg;
    logic signed [63:0] s1_prod_reg;
    logic [63:0]        s1_sq_reg;
    logic [30:0]        s1_dual_reg;
    logic [CW-1:0]      s1_cnt_reg;
    logic signed [63:0] dot_reg, dot_next;
    logic [63:0]        norm_reg, norm_next;
    logic               accept, counted;
    logic [64:0]        dot_sum, norm_sum;
    logic signed [63:0] dot_new;
    logic [63:0]        norm_new;
    logic [JQ_CNT_W:0]  pending;

    // hold off input while the job queue may not take a closing row
    assign pending = {1'b0, q_count} + {{JQ_CNT_W{1'b0}}, (s1_valid_reg & s1_last_reg)};
    assign full    = (pending >= (JQ_CNT_W + 1)'(JQ_DEPTH));
    assign accept  = push & ~full;
    assign counted = (cnt_reg < CW'(MAX_FEATURES));

    // count elements of the open row
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (in_data.row_end)
                cnt_next = '0;
            else if (counted)
                cnt_next = cnt_reg + CW'(1);
        end
    end

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= in_data.row_end;
            s1_use_reg  <= counted;
            s1_prod_reg <= in_data.feature_value * in_data.primal_value;
            s1_sq_reg   <= 64'(in_data.feature_value * in_data.feature_value);
            s1_dual_reg <= in_data.dual_value;
            s1_cnt_reg  <= counted ? cnt_reg + CW'(1) : cnt_reg;
        end
    end

    // saturating accumulate
    assign dot_sum  = {dot_reg[63], dot_reg} + {s1_prod_reg[63], s1_prod_reg};
    assign norm_sum = {1'b0, norm_reg} + {1'b0, s1_sq_reg};

    always_comb
    begin
        priority if (!s1_use_reg)
            dot_new = dot_reg;
        else if (dot_sum[64] != dot_sum[63])
            dot_new = dot_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            dot_new = dot_sum[63:0];
        priority if (!s1_use_reg)
            norm_new = norm_reg;
        else if (norm_sum[64])
            norm_new = '1;
        else
            norm_new = norm_sum[63:0];
    end

    always_comb
    begin
        dot_next  = dot_reg;
        norm_next = norm_reg;
        if (s1_valid_reg)
        begin
            dot_next  = s1_last_reg ? '0 : dot_new;
            norm_next = s1_last_reg ? '0 : norm_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            norm_reg <= '0;
        end
        else
        begin
            dot_reg  <= dot_next;
            norm_reg <= norm_next;
        end
    end

    // close the row
    assign job_push  = s1_valid_reg & s1_last_reg;
    assign job.norm  = norm_new;
    assign job.dot   = dot_new;
    assign job.cnt   = CNT_W_MAX'(s1_cnt_reg);
    assign job.dual  = s1_dual_reg;

`include "sdca_dual_coordinate_step_assert.svh"
    `SDCA_ASSERT_NOW(a_full_at_depth, (q_count == JQ_CNT_W'(JQ_DEPTH)), full)
    `SDCA_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_reg <= CW'(MAX_FEATURES)))
    `SDCA_ASSERT_NEXT(a_close_clears, job_push, (dot_reg == '0 && norm_reg == '0))

endmodule

[hdl/sdca_jobq.sv]
// Job queue between the accumulating front and the solver
`timescale 1ns / 1ps
module sdca_jobq
    import sdca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  job_t                wr_job,
    input  logic                rd,
    output job_t                rd_job,
    output logic                valid,
    output logic [JQ_CNT_W-1:0] count
);

    localparam int PW = $clog2(JQ_DEPTH);

    job_t                mem [JQ_DEPTH];
    logic [PW-1:0]       wp_reg, rp_reg;
    logic [JQ_CNT_W-1:0] count_reg;
    logic                do_rd;

    assign valid  = (count_reg != '0);
    assign count  = count_reg;
    assign do_rd  = rd & valid;
    assign rd_job = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_job;
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= rp_reg + PW'(1);
            count_reg <= count_reg + JQ_CNT_W'(wr) - JQ_CNT_W'(do_rd);
        end
    end

`include "sdca_dual_coordinate_step_assert.svh"
    `SDCA_ASSERT_NOW(a_no_overflow, (count_reg == JQ_CNT_W'(JQ_DEPTH)), !wr)

endmodule

[hdl/sdca_back.sv]
// Solver: bit-serial search for the root of the dual update quadratic
`timescale 1ns / 1ps
module sdca_back
    import sdca_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    input  logic [30:0] l2_strength,
    input  logic [30:0] dual_ceiling,
    output logic        res_valid,
    output out_item_t   res,
    input  logic        res_ready
);

    localparam int CW  = $clog2(MAX_FEATURES + 1);
    localparam int LCW = 31 + CW;
    localparam int GW  = 128 + CW;
    localparam int IW  = $clog2(LCW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LC   = 3'd1;
    localparam logic [2:0] ST_SER  = 3'd2;
    localparam logic [2:0] ST_P1   = 3'd3;
    localparam logic [2:0] ST_P2   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]           state_reg;
    logic [63:0]          norm_reg;
    logic signed [63:0]   dot_reg;
    logic [CW-1:0]        cnt_reg;
    logic [30:0]          dual_reg, ds_reg;
    logic                 zero_reg;
    logic [LCW-1:0]       lc_reg, lcs_reg;
    logic signed [GW-1:0] pa_reg, na_reg, t_reg, s_reg, nb_reg, w_reg;
    logic [IW-1:0]        i_reg;
    logic [4:0]           j_reg;
    logic [30:0]          x_reg, xc;
    logic [30:0]          l_eff;
    logic signed [GW-1:0] g, t_step;
    logic signed [31:0]   delta;

    assign l_eff  = (l2_strength == '0) ? 31'd1 : l2_strength;
    assign job_pop = (state_reg == ST_IDLE) & job_valid;
    assign t_step = (lcs_reg[0] ? pa_reg : '0) - (ds_reg[0] ? na_reg : '0);
    assign g      = s_reg + (w_reg <<< j_reg);

    // sequence one job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                        state_reg <= (job.norm == '0) ? ST_FIN : ST_LC;
                end
                ST_LC:
                    state_reg <= ST_SER;
                ST_SER:
                begin
                    if (i_reg == IW'(LCW - 1))
                        state_reg <= ST_P1;
                end
                ST_P1:
                    state_reg <= ST_P2;
                ST_P2:
                    state_reg <= (j_reg == 5'd0) ? ST_FIN : ST_P1;
                ST_FIN:
                begin
                    if (res_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                norm_reg <= job.norm;
                dot_reg  <= job.dot;
                cnt_reg  <= job.cnt[CW-1:0];
                dual_reg <= job.dual;
                zero_reg <= (job.norm == '0);
                x_reg    <= '0;
            end
            ST_LC:
            begin
                lc_reg  <= LCW'(l_eff * cnt_reg);
                lcs_reg <= LCW'(l_eff * cnt_reg);
                pa_reg  <= GW'(dot_reg);
                na_reg  <= GW'(norm_reg);
                ds_reg  <= dual_reg;
                t_reg   <= '0;
                i_reg   <= '0;
            end
            ST_SER:
            begin
                // T = P*L*c - N*d, one bit of each multiplier a cycle
                t_reg   <= t_reg + t_step;
                pa_reg  <= pa_reg <<< 1;
                na_reg  <= na_reg <<< 1;
                lcs_reg <= lcs_reg >> 1;
                ds_reg  <= ds_reg >> 1;
                i_reg   <= i_reg + IW'(1);
                s_reg   <= -(GW'(lc_reg) <<< (3 * FRAC_BITS));
                nb_reg  <= GW'(norm_reg) <<< 30;
                j_reg   <= 5'd30;
                x_reg   <= '0;
            end
            ST_P1:
                w_reg <= t_reg + nb_reg;
            ST_P2:
            begin
                // keep the bit while the quadratic stays at or below zero
                if (g[GW-1] || g == '0)
                begin
                    x_reg[j_reg] <= 1'b1;
                    s_reg        <= g;
                    t_reg        <= t_reg + (nb_reg <<< 1);
                end
                nb_reg <= nb_reg >>> 1;
                j_reg  <= j_reg - 5'd1;
            end
            ST_FIN:
                ;
            default:
                ;
        endcase
    end

    // clamp and form the result
    assign xc    = (x_reg > dual_ceiling) ? dual_ceiling : x_reg;
    assign delta = {1'b0, xc} - {1'b0, dual_reg};

    assign res_valid      = (state_reg == ST_FIN);
    assign res.delta_dual = zero_reg ? 32'sd0 : delta;
    assign res.zero_norm  = zero_reg;

`include "sdca_dual_coordinate_step_assert.svh"
    `SDCA_ASSERT_NOW(a_pop_idle, job_pop, (state_reg == ST_IDLE))
    `SDCA_ASSERT_NEXT(a_fin_hold, (res_valid && !res_ready), res_valid)

endmodule

[hdl/sdca_dual_coordinate_step.sv]
// Top level: configuration registers, front, job queue, solver and result register
`timescale 1ns / 1ps
// Dual coordinate step: feature/primal pairs are taken one per cycle and
// accumulated; each row end hands the row's sums to a four-entry job queue
// while the next row keeps streaming. The solver takes one row at a time;
// its work is set by the bit-serial multiply and the 31-bit root search,
// which settles one root bit per pass through states P1 and P2; a
// zero-norm row skips both and goes straight to the result. Input
// stalls (full) only when the queued rows plus a row closing in the front
// reach four.
module sdca_dual_coordinate_step
    import sdca_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_data,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0]         l2_reg, ceil_reg;
    logic                cfg_wr;
    logic                job_push, job_pop, job_valid;
    job_t                job_in, job_out;
    logic [JQ_CNT_W-1:0] q_count;
    logic                res_valid, res_ready;
    out_item_t           res;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_CEIL) ? {1'b0, ceil_reg} : {1'b0, l2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l2_reg   <= L2_RESET;
            ceil_reg <= CEIL_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_L2)
                l2_reg <= pwdata[30:0];
            else
                ceil_reg <= pwdata[30:0];
        end
    end

    sdca_front #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .full     (full),
        .q_count  (q_count),
        .job_push (job_push),
        .job      (job_in)
    );

    sdca_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (job_in),
        .rd     (job_pop),
        .rd_job (job_out),
        .valid  (job_valid),
        .count  (q_count)
    );

    sdca_back #(
        .MAX_FEATURES (MAX_FEATURES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job_out),
        .job_pop      (job_pop),
        .l2_strength  (l2_reg),
        .dual_ceiling (ceil_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready)
    );

    // result register: hold a beat until popped
    assign res_ready = ~out_valid_reg | pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_data_reg <= res;
    end

    assign empty    = ~out_valid_reg;
    assign out_data = out_data_reg;

endmodule
